>>> rtl/wpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM extract package
// Shared widths, constants, result codes and the volume scale table.
// ----------------------------------------------------------------------------
package wpe_pkg;

   localparam int LENGTH_BITS_DEF = 32;
   localparam int DATA_W          = 8;
   localparam int SAMPLE_W        = 16;
   localparam int KIND_W          = 3;
   localparam int VOL_W           = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int CHUNK_W         = 32;
   localparam int SUM_W           = 35;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam int MIN_CLIP      = 44;
   localparam int FIRST_CHUNK   = 12;
   localparam int CHUNK_HDR_LEN = 8;
   localparam int VOL_MAX       = 10;

   localparam int SCALE_SHIFT = 22;
   localparam int SCALE_RECIP = 419431;
   localparam int FACTOR_W    = 23;
   localparam int PROD_W      = SAMPLE_W + FACTOR_W;

   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_HDR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OVERRUN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NO_DATA = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } rslt_type;

   // Volume times a fixed-point reciprocal of ten, so one multiply scales a sample.
   function automatic logic [FACTOR_W-1:0] vol_factor(input logic [VOL_W-1:0] vol);
      logic [FACTOR_W-1:0] f;
      case (vol)
         4'd0:    f = '0;
         4'd1:    f = FACTOR_W'(1 * SCALE_RECIP);
         4'd2:    f = FACTOR_W'(2 * SCALE_RECIP);
         4'd3:    f = FACTOR_W'(3 * SCALE_RECIP);
         4'd4:    f = FACTOR_W'(4 * SCALE_RECIP);
         4'd5:    f = FACTOR_W'(5 * SCALE_RECIP);
         4'd6:    f = FACTOR_W'(6 * SCALE_RECIP);
         4'd7:    f = FACTOR_W'(7 * SCALE_RECIP);
         4'd8:    f = FACTOR_W'(8 * SCALE_RECIP);
         4'd9:    f = FACTOR_W'(9 * SCALE_RECIP);
         default: f = FACTOR_W'(VOL_MAX * SCALE_RECIP);
      endcase
      return f;
   endfunction

endpackage

>>> rtl/wpe_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM extract register file
// Holds the clip length and volume registers behind the APB-style port.
// ----------------------------------------------------------------------------
module wpe_csr
   import wpe_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready,
   output logic [LENGTH_BITS-1:0] clip_length,
   output logic [VOL_W-1:0]       volume
);

   localparam logic REG_CLIP = 1'b0;
   localparam logic REG_VOL  = 1'b1;

   logic [LENGTH_BITS-1:0] clip_ff, clip_in;
   logic [VOL_W-1:0]       vol_ff, vol_in;
   logic                   wr_en;
   logic [VOL_W-1:0]       wr_vol;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_vol = pwdata[VOL_W-1:0];

   always_comb begin
      clip_in = clip_ff;
      vol_in  = vol_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_CLIP: clip_in = pwdata[LENGTH_BITS-1:0];
            REG_VOL: begin
               if (wr_vol > VOL_W'(VOL_MAX)) begin
                  vol_in = VOL_W'(VOL_MAX);
               end else begin
                  vol_in = wr_vol;
               end
            end
            default: clip_in = clip_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CLIP: prdata = CSR_DATA_W'(clip_ff);
         REG_VOL:  prdata = CSR_DATA_W'(vol_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= '0;
         vol_ff  <= VOL_W'(6);
      end else begin
         clip_ff <= clip_in;
         vol_ff  <= vol_in;
      end
   end

   assign clip_length = clip_ff;
   assign volume      = vol_ff;

endmodule

>>> rtl/wpe_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM extract sample scaler
// Scales a signed 16-bit sample by volume over ten, truncating toward zero.
// ----------------------------------------------------------------------------
module wpe_scale
   import wpe_pkg::*;
(
   input  logic [SAMPLE_W-1:0]        raw,
   input  logic [VOL_W-1:0]           volume,
   output logic signed [SAMPLE_W-1:0] sample
);

   logic                neg;
   logic [SAMPLE_W-1:0] mag;
   logic [PROD_W-1:0]   prod;
   logic [SAMPLE_W-1:0] quot;

   // The magnitude is scaled so that truncation toward zero falls out of the floor.
   always_comb begin
      neg    = raw[SAMPLE_W-1];
      mag    = neg ? SAMPLE_W'(-raw) : raw;
      prod   = PROD_W'(mag) * PROD_W'(vol_factor(volume));
      quot   = prod[SCALE_SHIFT +: SAMPLE_W];
      sample = neg ? SAMPLE_W'(-quot) : quot;
   end

endmodule

>>> rtl/wpe_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM extract parser
// Walks the RIFF header and chunk headers one byte per step and forms results.
// ----------------------------------------------------------------------------
module wpe_parser
   import wpe_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [DATA_W-1:0]      data_byte,
   input  logic [LENGTH_BITS-1:0] clip_length,
   input  logic [VOL_W-1:0]       volume,
   output logic                   evt_valid,
   output rslt_type               evt
);

   localparam logic [2:0] PH_RIFF  = 3'd0;
   localparam logic [2:0] PH_CHDR  = 3'd1;
   localparam logic [2:0] PH_SKIP  = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_DRAIN = 3'd4;

   logic [2:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [CHUNK_W-1:0]     rem_ff, rem_in;
   logic [63:0]            hdr_ff, hdr_in;
   logic [DATA_W-1:0]      low_ff, low_in;
   logic                   pad_ff, pad_in;
   logic                   ok_ff, ok_in;

   logic [63:0]            hdr_shift;
   logic [31:0]            tag;
   logic [CHUNK_W-1:0]     size;
   logic [SUM_W-1:0]       p_ext, size_ext, clen_ext;
   logic                   overrun, no_room;
   logic [CHUNK_W-1:0]     rem_dec;
   logic [LENGTH_BITS-1:0] pos_next;
   logic                   pad_next;
   logic signed [SAMPLE_W-1:0] scaled;

   wpe_scale u_scale (
      .raw    ({data_byte, low_ff}),
      .volume (volume),
      .sample (scaled)
   );

   always_comb begin
      hdr_shift = {hdr_ff[55:0], data_byte};
      tag       = hdr_shift[63:32];
      size      = {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16], hdr_shift[31:24]};
      p_ext     = SUM_W'(pos_ff);
      size_ext  = SUM_W'(size);
      clen_ext  = SUM_W'(clip_length);
      overrun   = (p_ext + size_ext + SUM_W'(1)) > clen_ext;
      no_room   = (p_ext + size_ext + SUM_W'(CHUNK_HDR_LEN + 1) + SUM_W'(size[0])) > clen_ext;
      rem_dec   = (rem_ff != '0) ? rem_ff - CHUNK_W'(1) : '0;
      pos_next  = pos_ff + LENGTH_BITS'(1);
      pad_next  = (rem_ff != '0) && pad_ff;

      phase_in  = phase_ff;
      pos_in    = pos_next;
      rem_in    = rem_ff;
      hdr_in    = hdr_shift;
      low_in    = low_ff;
      pad_in    = pad_ff;
      ok_in     = ok_ff;
      evt_valid = 1'b0;
      evt       = '{kind: KIND_SAMPLE, sample: '0, last: 1'b0};

      unique case (phase_ff)
         PH_CHDR: begin
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               if (overrun) begin
                  phase_in  = PH_DRAIN;
                  evt_valid = 1'b1;
                  evt       = '{kind: KIND_OVERRUN, sample: '0, last: 1'b1};
               end else if (tag == TAG_DATA) begin
                  if (size < CHUNK_W'(2)) begin
                     phase_in  = PH_DRAIN;
                     evt_valid = 1'b1;
                     evt       = '{kind: KIND_EMPTY, sample: '0, last: 1'b1};
                  end else begin
                     phase_in = PH_DATA;
                     rem_in   = size;
                     pad_in   = 1'b0;
                  end
               end else if (no_room) begin
                  phase_in  = PH_DRAIN;
                  evt_valid = 1'b1;
                  evt       = '{kind: KIND_NO_DATA, sample: '0, last: 1'b1};
               end else if (size == '0) begin
                  rem_in = CHUNK_W'(CHUNK_HDR_LEN);
               end else begin
                  phase_in = PH_SKIP;
                  rem_in   = size;
                  pad_in   = size[0];
               end
            end
         end
         PH_SKIP: begin
            rem_in = rem_dec;
            pad_in = pad_next;
            if ((rem_dec == '0) && !pad_next) begin
               phase_in = PH_CHDR;
               rem_in   = CHUNK_W'(CHUNK_HDR_LEN);
            end
         end
         PH_DATA: begin
            rem_in = rem_dec;
            if (!pad_ff) begin
               low_in = data_byte;
               pad_in = 1'b1;
            end else begin
               pad_in    = 1'b0;
               evt_valid = 1'b1;
               evt       = '{kind: KIND_SAMPLE, sample: scaled,
                             last: (rem_dec < CHUNK_W'(2))};
               if (rem_dec < CHUNK_W'(2)) begin
                  phase_in = PH_DRAIN;
               end
            end
         end
         PH_DRAIN: begin
            phase_in = PH_DRAIN;
         end
         default: begin
            phase_in = PH_RIFF;
            if ((pos_ff == '0) && (clen_ext < SUM_W'(MIN_CLIP))) begin
               phase_in  = PH_DRAIN;
               evt_valid = 1'b1;
               evt       = '{kind: KIND_BAD_HDR, sample: '0, last: 1'b1};
            end else begin
               if ((pos_ff == LENGTH_BITS'(3)) && (hdr_shift[31:0] != TAG_RIFF)) begin
                  ok_in = 1'b0;
               end
               if (pos_ff == LENGTH_BITS'(11)) begin
                  if (!ok_ff || (hdr_shift[31:0] != TAG_WAVE)) begin
                     phase_in  = PH_DRAIN;
                     evt_valid = 1'b1;
                     evt       = '{kind: KIND_BAD_HDR, sample: '0, last: 1'b1};
                  end else if (clen_ext < SUM_W'(FIRST_CHUNK + CHUNK_HDR_LEN)) begin
                     phase_in  = PH_DRAIN;
                     evt_valid = 1'b1;
                     evt       = '{kind: KIND_NO_DATA, sample: '0, last: 1'b1};
                  end else begin
                     phase_in = PH_CHDR;
                     rem_in   = CHUNK_W'(CHUNK_HDR_LEN);
                  end
               end
            end
         end
      endcase

      // The parser starts over once the clip's byte count is reached.
      if ((pos_next >= clip_length) || (pos_next == '0)) begin
         phase_in = PH_RIFF;
         pos_in   = '0;
         rem_in   = '0;
         hdr_in   = '0;
         low_in   = '0;
         pad_in   = 1'b0;
         ok_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         pos_ff   <= '0;
         rem_ff   <= '0;
         pad_ff   <= 1'b0;
         ok_ff    <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         pad_ff   <= pad_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hdr_ff <= hdr_in;
         low_ff <= low_in;
      end
   end

endmodule

>>> rtl/wav_pcm_extract_volume_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM extract with volume
// Parses a RIFF/WAVE byte stream and delivers volume-scaled 16-bit samples.
// ----------------------------------------------------------------------------
// The block accepts one clip byte per cycle while the result register is
// free or being taken. A byte is held in an input register and goes from
// there through the single-pass parser and scaler. Any result it causes is
// loaded into the result register as the byte leaves the input register, so
// a result passes both registers before it is shown. The result register
// lets the next byte in while an earlier result waits; the block stalls only
// when the result register is full and not being taken. Each clip ends with
// exactly one result carrying last, and any bytes after it up to the clip
// length are taken in silently. There is no clearing pass after reset.
module wav_pcm_extract_volume_unit
   import wpe_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [DATA_W-1:0]          req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [KIND_W-1:0]          rsp_kind,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic [LENGTH_BITS-1:0] clip_length;
   logic [VOL_W-1:0]       volume;

   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   rslt_type          out_ff;
   logic              advance;
   logic              evt_valid;
   rslt_type          evt;

   wpe_csr #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .clip_length (clip_length),
      .volume      (volume)
   );

   wpe_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .clip_length (clip_length),
      .volume      (volume),
      .evt_valid   (evt_valid),
      .evt         (evt)
   );

   always_comb begin
      advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end

      out_valid_in = out_valid_ff;
      if (advance && evt_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance && evt_valid) begin
         out_ff <= evt;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_kind   = out_ff.kind;
   assign rsp_sample = out_ff.sample;
   assign rsp_last   = out_ff.last;

endmodule

>>> dv/wav_pcm_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM stream checker
// Watches the byte, result and register channels of the WAV PCM extractor,
// tracks the clip parser state byte by byte, and compares every result
// transaction field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module wav_pcm_stream_checker
   import wpe_pkg::*;
#(
   parameter logic [CSR_ADDR_W-1:0] CLIP_LEN_ADDR = 3'd0,
   parameter logic [CSR_ADDR_W-1:0] VOLUME_ADDR   = 3'd4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [DATA_W-1:0]          req_data_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [KIND_W-1:0]          rsp_kind,
   input  logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   input  logic                       pready,
   output int                         pending_count,
   output int                         error_count
);

   typedef enum logic [2:0] {
      PARSE_RIFF,
      PARSE_CHUNK_HDR,
      PARSE_SKIP,
      PARSE_DATA,
      PARSE_DRAIN
   } parse_phase_type;

   logic [31:0]     clip_len;
   logic [3:0]      vol;
   parse_phase_type phase;
   logic [31:0]     byte_pos;
   logic [31:0]     chunk_left;
   logic [63:0]     hdr_shift;
   logic [7:0]      low_byte;
   logic            pad_pending;
   logic            header_ok;
   rslt_type        parsed_results[$];
   int              errors = 0;

   function automatic void clear_parser();
      phase       = PARSE_RIFF;
      byte_pos    = '0;
      chunk_left  = '0;
      hdr_shift   = '0;
      low_byte    = '0;
      pad_pending = 1'b0;
      header_ok   = 1'b1;
   endfunction

   function automatic bit end_clip(input logic [KIND_W-1:0] kind, output rslt_type res);
      res      = '0;
      res.kind = kind;
      res.last = 1'b1;
      phase    = PARSE_DRAIN;
      return 1'b1;
   endfunction

   function automatic bit open_chunk(input logic [63:0] ofs, output rslt_type res);
      res = '0;
      if (ofs + 64'd8 > 64'(clip_len)) begin
         return end_clip(KIND_NO_DATA, res);
      end
      phase      = PARSE_CHUNK_HDR;
      chunk_left = 32'(CHUNK_HDR_LEN);
      return 1'b0;
   endfunction

   function automatic bit parse_clip_byte(input logic [7:0] b, output rslt_type res);
      logic [63:0] pos;
      logic [63:0] size;
      logic [63:0] ofs;
      logic [15:0] raw;
      int          scaled;
      bit          hit;
      res       = '0;
      hit       = 1'b0;
      pos       = 64'(byte_pos);
      hdr_shift = {hdr_shift[55:0], b};
      case (phase)
         PARSE_CHUNK_HDR: begin
            if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
            if (chunk_left == 0) begin
               size = 64'({hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16],
                           hdr_shift[31:24]});
               if (pos + 64'd1 + size > 64'(clip_len)) begin
                  hit = end_clip(KIND_OVERRUN, res);
               end else if (hdr_shift[63:32] == TAG_DATA) begin
                  if (size < 64'd2) begin
                     hit = end_clip(KIND_EMPTY, res);
                  end else begin
                     phase       = PARSE_DATA;
                     chunk_left  = size[31:0];
                     pad_pending = 1'b0;
                  end
               end else begin
                  ofs = pos + 64'd1 + size + 64'(size[0]);
                  if (size == 64'd0) begin
                     hit = open_chunk(ofs, res);
                  end else if (ofs + 64'd8 > 64'(clip_len)) begin
                     hit = end_clip(KIND_NO_DATA, res);
                  end else begin
                     phase       = PARSE_SKIP;
                     chunk_left  = size[31:0];
                     pad_pending = size[0];
                  end
               end
            end
         end
         PARSE_SKIP: begin
            if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
            else pad_pending = 1'b0;
            if (chunk_left == 0 && !pad_pending) begin
               phase      = PARSE_CHUNK_HDR;
               chunk_left = 32'(CHUNK_HDR_LEN);
            end
         end
         PARSE_DATA: begin
            if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
            if (!pad_pending) begin
               low_byte    = b;
               pad_pending = 1'b1;
            end else begin
               raw    = {b, low_byte};
               scaled = (int'($signed(raw)) * int'(vol)) / VOL_MAX;
               if (scaled > 32767) scaled = 32767;
               else if (scaled < -32768) scaled = -32768;
               pad_pending = 1'b0;
               res.kind    = KIND_SAMPLE;
               res.sample  = 16'(scaled);
               res.last    = (chunk_left < 32'd2);
               hit         = 1'b1;
               if (res.last) phase = PARSE_DRAIN;
            end
         end
         PARSE_DRAIN: begin
         end
         default: begin
            phase = PARSE_RIFF;
            if (pos == 64'd0 && clip_len < 32'(MIN_CLIP)) begin
               hit = end_clip(KIND_BAD_HDR, res);
            end else begin
               if (pos == 64'd3 && hdr_shift[31:0] != TAG_RIFF) header_ok = 1'b0;
               if (pos == 64'd11) begin
                  if (hdr_shift[31:0] != TAG_WAVE) header_ok = 1'b0;
                  if (!header_ok) hit = end_clip(KIND_BAD_HDR, res);
                  else hit = open_chunk(64'(FIRST_CHUNK), res);
               end
            end
         end
      endcase
      byte_pos = byte_pos + 32'd1;
      if (byte_pos >= clip_len || byte_pos == 0) clear_parser();
      return hit;
   endfunction

   always @(posedge clock) begin
      rslt_type calc;
      rslt_type want;
      if (reset) begin
         clip_len = '0;
         vol      = 4'd6;
         clear_parser();
         parsed_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == CLIP_LEN_ADDR) begin
               clip_len = pwdata;
            end else if (paddr == VOLUME_ADDR) begin
               vol = (pwdata[3:0] > 4'(VOL_MAX)) ? 4'(VOL_MAX) : pwdata[3:0];
            end
         end
         if (req_valid && req_ready) begin
            if (parse_clip_byte(req_data_byte, calc)) parsed_results.push_back(calc);
         end
         if (rsp_valid && rsp_ready) begin
            if (parsed_results.size() == 0) begin
               $error("Unexpected result transaction: kind %0d, sample %0d, last %0d",
                      rsp_kind, rsp_sample, rsp_last);
               errors++;
            end else begin
               want = parsed_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_kind);
                  errors++;
               end
               if (rsp_sample !== want.sample) begin
                  $error("sample mismatch: expected %0d, actual %0d", want.sample,
                         rsp_sample);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
      pending_count <= parsed_results.size();
      error_count   <= errors;
   end

endmodule

>>> dv/wav_pcm_extract_volume_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV PCM extract with volume testbench
// Feeds RIFF/WAVE clips byte by byte, both well-formed and broken, under
// changing clip length and volume settings and several flow-control patterns,
// and reports the verdict from the stream checker's error and pending counts.
// ----------------------------------------------------------------------------
module wav_pcm_extract_volume_unit_tb;
   import wpe_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_ITEMS   = 1725;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int NUM_FLAVORS    = 9;

   localparam logic [CSR_ADDR_W-1:0] CSR_CLIP_LEN = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME   = 3'd4;

   typedef enum int {
      F_GOOD,
      F_ODD_DATA,
      F_EMPTY_DATA,
      F_NO_DATA,
      F_OVERRUN_DATA,
      F_OVERRUN_SKIP,
      F_BAD_RIFF,
      F_BAD_WAVE,
      F_SHORT
   } clip_flavor_type;

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [DATA_W-1:0]          req_data_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [KIND_W-1:0]          rsp_kind;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_last;
   logic                       psel          = 1'b0;
   logic                       penable       = 1'b0;
   logic                       pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr         = '0;
   logic [CSR_DATA_W-1:0]      pwdata        = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   int          pending_count;
   int          error_count;
   int          send_gap_pct  = 0;
   int          stall_pct     = 0;
   int          hold_asks     = 0;
   int          hold_seen     = 0;
   int          stuck_cycles  = 0;
   logic [7:0]  clip_bytes[$];
   int          send_gap_tbl[4]  = '{0, 83, 0, 19};
   int          stall_tbl[4]     = '{0, 0, 83, 19};

   wav_pcm_extract_volume_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_sample    (rsp_sample),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   wav_pcm_stream_checker #(
      .CLIP_LEN_ADDR (CSR_CLIP_LEN),
      .VOLUME_ADDR   (CSR_VOLUME)
   ) stream_chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_sample    (rsp_sample),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void add_tag(input logic [31:0] t);
      clip_bytes.push_back(t[31:24]);
      clip_bytes.push_back(t[23:16]);
      clip_bytes.push_back(t[15:8]);
      clip_bytes.push_back(t[7:0]);
   endfunction

   function automatic void add_le32(input logic [31:0] v);
      clip_bytes.push_back(v[7:0]);
      clip_bytes.push_back(v[15:8]);
      clip_bytes.push_back(v[23:16]);
      clip_bytes.push_back(v[31:24]);
   endfunction

   function automatic logic [31:0] other_tag();
      logic [31:0] t;
      t = $urandom();
      if (t == TAG_DATA) t[0] = ~t[0];
      return t;
   endfunction

   function automatic void add_skip_chunk(input int unsigned sz);
      add_tag(other_tag());
      add_le32(sz);
      repeat (sz + (sz % 2)) clip_bytes.push_back(8'($urandom()));
   endfunction

   function automatic void build_clip(input clip_flavor_type flavor, input bit big);
      int unsigned data_len;
      int          need;
      int unsigned cut;
      int unsigned idx;
      logic [31:0] declared;
      clip_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32($urandom());
      add_tag(TAG_WAVE);
      repeat ($urandom_range(0, 2)) add_skip_chunk($urandom_range(0, 9));
      case (flavor)
         F_ODD_DATA:   data_len = 2 * $urandom_range(1, 20) + 1;
         F_EMPTY_DATA: data_len = $urandom_range(0, 1);
         default:      data_len = big ? 120 : 2 * $urandom_range(1, 30);
      endcase
      if (flavor == F_NO_DATA) begin
         need = 36 - clip_bytes.size();
         add_skip_chunk(need > 0 ? need : $urandom_range(0, 3));
         repeat ($urandom_range(0, 7)) clip_bytes.push_back(8'($urandom()));
      end else begin
         if (flavor == F_OVERRUN_SKIP) begin
            add_tag(other_tag());
            add_le32($urandom() | 32'h0000_0100);
         end else begin
            declared = data_len;
            if (flavor == F_OVERRUN_DATA) begin
               declared = $urandom_range(0, 1) ? 32'hFFFF_FFFF : data_len + $urandom_range(50, 500);
            end
            add_tag(TAG_DATA);
            add_le32(declared);
            repeat (data_len) clip_bytes.push_back(8'($urandom()));
         end
         repeat ($urandom_range(0, 3)) clip_bytes.push_back(8'($urandom()));
         while (clip_bytes.size() < MIN_CLIP) clip_bytes.push_back(8'($urandom()));
      end
      case (flavor)
         F_BAD_RIFF: begin
            idx = $urandom_range(0, 3);
            clip_bytes[idx] = clip_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
         end
         F_BAD_WAVE: begin
            idx = $urandom_range(8, 11);
            clip_bytes[idx] = clip_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
         end
         F_SHORT: begin
            cut = $urandom_range(1, MIN_CLIP - 1);
            while (clip_bytes.size() > cut) void'(clip_bytes.pop_back());
         end
         default: begin
         end
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_clip();
      foreach (clip_bytes[i]) send_byte(clip_bytes[i]);
   endtask

   task automatic settle_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clip_flavor_type flavor;
      bit              pressure;
      int              clip_idx;
      int              sent;
      int              vol_pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_VOLUME, 32'hFFFF_FFFF);
      csr_write(CSR_CLIP_LEN, 32'd0);
      send_byte(8'h00);
      send_byte(8'hFF);
      settle_results();

      csr_write(CSR_CLIP_LEN, 32'hFFFF_FFFF);
      clip_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32(32'd0);
      add_tag(TAG_WAVE);
      add_tag(TAG_DATA);
      add_le32(32'd2);
      clip_bytes.push_back(8'h00);
      clip_bytes.push_back(8'h80);
      send_clip();
      settle_results();

      // A new length of zero ends the open clip on the next byte.
      csr_write(CSR_CLIP_LEN, 32'd0);
      send_byte(8'hA5);
      send_byte(8'h5A);
      settle_results();

      clip_idx = 0;
      sent     = 0;
      while (sent < RANDOM_ITEMS) begin
         send_gap_pct = send_gap_tbl[(clip_idx / 2) % 4];
         stall_pct    = stall_tbl[(clip_idx / 2) % 4];
         pressure     = (clip_idx % 10 == 3);
         if (pressure) flavor = F_GOOD;
         else if (clip_idx < NUM_FLAVORS) flavor = clip_flavor_type'(clip_idx);
         else begin
            vol_pick = $urandom_range(0, 16);
            flavor   = (vol_pick < 9) ? F_GOOD : clip_flavor_type'(vol_pick - 8);
         end
         build_clip(flavor, pressure);
         csr_write(CSR_CLIP_LEN, clip_bytes.size());
         if (clip_idx == 0) csr_write(CSR_VOLUME, 32'd0);
         else if (clip_idx == 1) csr_write(CSR_VOLUME, 32'(VOL_MAX));
         else if ($urandom_range(0, 2) == 0) begin
            csr_write(CSR_VOLUME, {28'($urandom()), 4'($urandom_range(0, 15))});
         end
         if (pressure) hold_asks++;
         send_clip();
         sent += clip_bytes.size();
         settle_results();
         clip_idx++;
      end

      settle_results();
      if (error_count == 0 && pending_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
